FILE: hw/rtl/lucc_pkg.sv
package lucc_pkg;

    localparam int MODE_W   = 4;
    localparam int SIZE_W   = 2;
    localparam int DATA_W   = 32;
    localparam int COND_W   = 4;
    localparam int STATUS_W = 16;

    // operation codes
    localparam logic [MODE_W-1:0] MODE_AND     = 4'd0;
    localparam logic [MODE_W-1:0] MODE_OR      = 4'd1;
    localparam logic [MODE_W-1:0] MODE_EOR     = 4'd2;
    localparam logic [MODE_W-1:0] MODE_NOT     = 4'd3;
    localparam logic [MODE_W-1:0] MODE_TST     = 4'd4;
    localparam logic [MODE_W-1:0] MODE_SCC     = 4'd5;
    localparam logic [MODE_W-1:0] MODE_AND_SR  = 4'd6;
    localparam logic [MODE_W-1:0] MODE_AND_CCR = 4'd7;
    localparam logic [MODE_W-1:0] MODE_OR_SR   = 4'd8;
    localparam logic [MODE_W-1:0] MODE_OR_CCR  = 4'd9;

    // operand sizes
    localparam logic [SIZE_W-1:0] SIZE_BYTE = 2'd0;
    localparam logic [SIZE_W-1:0] SIZE_WORD = 2'd1;

    // conditions
    localparam logic [COND_W-1:0] CC_T  = 4'd0;
    localparam logic [COND_W-1:0] CC_F  = 4'd1;
    localparam logic [COND_W-1:0] CC_HI = 4'd2;
    localparam logic [COND_W-1:0] CC_LS = 4'd3;
    localparam logic [COND_W-1:0] CC_CC = 4'd4;
    localparam logic [COND_W-1:0] CC_CS = 4'd5;
    localparam logic [COND_W-1:0] CC_NE = 4'd6;
    localparam logic [COND_W-1:0] CC_EQ = 4'd7;
    localparam logic [COND_W-1:0] CC_VC = 4'd8;
    localparam logic [COND_W-1:0] CC_VS = 4'd9;
    localparam logic [COND_W-1:0] CC_PL = 4'd10;
    localparam logic [COND_W-1:0] CC_MI = 4'd11;
    localparam logic [COND_W-1:0] CC_GE = 4'd12;
    localparam logic [COND_W-1:0] CC_LT = 4'd13;
    localparam logic [COND_W-1:0] CC_GT = 4'd14;
    localparam logic [COND_W-1:0] CC_LE = 4'd15;

    // ccr bit positions
    localparam int CCR_C = 0;
    localparam int CCR_V = 1;
    localparam int CCR_Z = 2;
    localparam int CCR_N = 3;

    localparam logic [STATUS_W-1:0] STATUS_RESET = 16'h2700;
    localparam logic [STATUS_W-1:0] CCR_KEEP     = 16'hFFE0;
    localparam logic [STATUS_W-1:0] CCR_MASK     = 16'h001F;
    localparam logic [DATA_W-1:0]   BYTE_MASK    = 32'h0000_00FF;
    localparam logic [DATA_W-1:0]   WORD_MASK    = 32'h0000_FFFF;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [SIZE_W-1:0] op_size;
        logic [DATA_W-1:0] src_value;
        logic [DATA_W-1:0] dst_value;
        logic [COND_W-1:0] cond_code;
    } t_in_item;

    typedef struct packed {
        logic [DATA_W-1:0]   result_value;
        logic                write_enable;
        logic [STATUS_W-1:0] status_out;
    } t_out_item;

endpackage

FILE: hw/rtl/lucc_in_if.sv
interface lucc_in_if;
    logic        valid;
    logic        ready;
    logic [3:0]  mode;
    logic [1:0]  op_size;
    logic [31:0] src_value;
    logic [31:0] dst_value;
    logic [3:0]  cond_code;

    modport source (
        output valid, mode, op_size, src_value, dst_value, cond_code,
        input  ready
    );
    modport sink (
        input  valid, mode, op_size, src_value, dst_value, cond_code,
        output ready
    );
endinterface

FILE: hw/rtl/lucc_out_if.sv
interface lucc_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] result_value;
    logic        write_enable;
    logic [15:0] status_out;

    modport source (
        output valid, result_value, write_enable, status_out,
        input  ready
    );
    modport sink (
        input  valid, result_value, write_enable, status_out,
        output ready
    );
endinterface

FILE: hw/rtl/lucc_alu.sv
module lucc_alu import lucc_pkg::*; (
    input  t_in_item            i_item,
    input  logic [STATUS_W-1:0] i_status,
    output t_out_item           o_res
);

    logic [DATA_W-1:0]   size_mask;
    logic [DATA_W-1:0]   logic_val;
    logic                msb;
    logic [STATUS_W-1:0] flag_status;
    logic [STATUS_W-1:0] imm16;
    logic [STATUS_W-1:0] imm8;
    logic                c, v, z, n;
    logic                cond_ok;

    assign c     = i_status[CCR_C];
    assign v     = i_status[CCR_V];
    assign z     = i_status[CCR_Z];
    assign n     = i_status[CCR_N];
    assign imm16 = i_item.src_value[STATUS_W-1:0];
    assign imm8  = {8'd0, i_item.src_value[7:0]};

    always_comb begin
        case (i_item.op_size)
            SIZE_BYTE: size_mask = BYTE_MASK;
            SIZE_WORD: size_mask = WORD_MASK;
            default:   size_mask = '1;
        endcase
    end

    always_comb begin
        case (i_item.mode)
            MODE_AND: logic_val = i_item.src_value & i_item.dst_value & size_mask;
            MODE_OR:  logic_val = (i_item.src_value | i_item.dst_value) & size_mask;
            MODE_EOR: logic_val = (i_item.src_value ^ i_item.dst_value) & size_mask;
            MODE_NOT: logic_val = ~i_item.dst_value & size_mask;
            default:  logic_val = i_item.dst_value & size_mask;
        endcase
    end

    always_comb begin
        case (i_item.op_size)
            SIZE_BYTE: msb = logic_val[7];
            SIZE_WORD: msb = logic_val[15];
            default:   msb = logic_val[31];
        endcase
    end

    always_comb begin
        flag_status        = i_status;
        flag_status[CCR_C] = 1'b0;
        flag_status[CCR_V] = 1'b0;
        flag_status[CCR_Z] = (logic_val == '0);
        flag_status[CCR_N] = msb;
    end

    always_comb begin
        case (i_item.cond_code)
            CC_T:    cond_ok = 1'b1;
            CC_F:    cond_ok = 1'b0;
            CC_HI:   cond_ok = !c && !z;
            CC_LS:   cond_ok = c || z;
            CC_CC:   cond_ok = !c;
            CC_CS:   cond_ok = c;
            CC_NE:   cond_ok = !z;
            CC_EQ:   cond_ok = z;
            CC_VC:   cond_ok = !v;
            CC_VS:   cond_ok = v;
            CC_PL:   cond_ok = !n;
            CC_MI:   cond_ok = n;
            CC_GE:   cond_ok = (n == v);
            CC_LT:   cond_ok = (n != v);
            CC_GT:   cond_ok = !z && (n == v);
            CC_LE:   cond_ok = z || (n != v);
            default: cond_ok = 1'b0;
        endcase
    end

    always_comb begin
        o_res.result_value = '0;
        o_res.write_enable = 1'b0;
        o_res.status_out   = i_status;
        case (i_item.mode)
            MODE_AND, MODE_OR, MODE_EOR, MODE_NOT: begin
                o_res.result_value = logic_val;
                o_res.write_enable = 1'b1;
                o_res.status_out   = flag_status;
            end
            MODE_TST: begin
                o_res.status_out = flag_status;
            end
            MODE_SCC: begin
                o_res.result_value = cond_ok ? BYTE_MASK : '0;
                o_res.write_enable = 1'b1;
            end
            MODE_AND_SR: begin
                o_res.status_out = i_status & imm16;
            end
            MODE_AND_CCR: begin
                o_res.status_out = (i_status & CCR_KEEP) | (i_status & imm8 & CCR_MASK);
            end
            MODE_OR_SR: begin
                o_res.status_out = i_status | imm16;
            end
            MODE_OR_CCR: begin
                o_res.status_out = (i_status & CCR_KEEP) | ((i_status | imm8) & CCR_MASK);
            end
            default: begin
                o_res.status_out = i_status;
            end
        endcase
    end

endmodule

FILE: hw/rtl/logic_unit_with_condition_codes.sv
// channel   | dir | payload
// i_item    | in  | mode, op_size, src_value, dst_value, cond_code
// o_res     | out | result_value, write_enable, status_out
//
// one item per cycle unless stalled; accepted items go to the item register,
// which feeds the logic unit, whose output and the status register
// are loaded together, so each item sees the status left by the one before
// synchronous active-low reset clears both stages and sets status to 0x2700
// a stalled result holds; the item register still fills behind it
module logic_unit_with_condition_codes import lucc_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    lucc_in_if.sink    i_item,
    lucc_out_if.source o_res
);

    t_in_item            r_in;
    logic                r_in_valid;
    t_out_item           r_out;
    logic                r_out_valid;
    logic [STATUS_W-1:0] r_status;
    t_out_item           n_out;
    logic                in_fire;
    logic                advance;

    assign advance      = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_item.ready = !r_in_valid || advance;
    assign in_fire      = i_item.valid && i_item.ready;

    lucc_alu u_alu (
        .i_item   (r_in),
        .i_status (r_status),
        .o_res    (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_status    <= STATUS_RESET;
        end else begin
            if (in_fire) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_status    <= n_out.status_out;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in.mode      <= i_item.mode;
            r_in.op_size   <= i_item.op_size;
            r_in.src_value <= i_item.src_value;
            r_in.dst_value <= i_item.dst_value;
            r_in.cond_code <= i_item.cond_code;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.result_value = r_out.result_value;
    assign o_res.write_enable = r_out.write_enable;
    assign o_res.status_out   = r_out.status_out;

endmodule
